// File: rtl/e1wrd_pkg.sv
// ----------------------------------------------------------------------------
// e1wrd_pkg
// Shared types, codes and helpers of the e1 waveform record decoder.
// ----------------------------------------------------------------------------
package e1wrd_pkg;

  localparam int MAX_ORDER_DEF   = 4;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int ORD_W           = 4;

  typedef enum logic [1:0] {
    KIND_HDR_SIZE  = 2'd0,
    KIND_HDR_CHECK = 2'd1,
    KIND_DATA      = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_DATA  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    MAP_9X7  = 3'd0,
    MAP_10X3 = 3'd1,
    MAP_7X4  = 3'd2,
    MAP_12X5 = 3'd3,
    MAP_15X4 = 3'd4,
    MAP_28X1 = 3'd5
  } map_e;

  // one queue entry: a header command or one decoded map group
  typedef struct packed {
    op_e              op;
    map_e             map;
    logic [ORD_W-1:0] ord;
    logic [2:0]       cnt;
    logic             ends;
    logic [63:0]      bits;
  } entry_t;

  // one word moving down the integrator chain
  typedef struct packed {
    logic             valid;
    op_e              op;
    logic [ORD_W-1:0] ord;
    logic             last;
    logic             ends;
    logic [31:0]      val;
  } tok_t;

  function automatic logic [4:0] map_fw(map_e m);
    logic [4:0] fw;
    unique case (m)
      MAP_9X7:  fw = 5'd9;
      MAP_10X3: fw = 5'd10;
      MAP_7X4:  fw = 5'd7;
      MAP_12X5: fw = 5'd12;
      MAP_15X4: fw = 5'd15;
      MAP_28X1: fw = 5'd28;
      default:  fw = 5'd28;
    endcase
    return fw;
  endfunction

endpackage

// File: rtl/e1wrd_front.sv
// ----------------------------------------------------------------------------
// e1wrd_front
// Takes record words, tracks record position and held map words, and queues
// header commands and sample groups for the back end.
// ----------------------------------------------------------------------------
module e1wrd_front #(
  parameter int MAX_ORDER = e1wrd_pkg::MAX_ORDER_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic              full_i,
  input  logic [1:0]        kind_i,
  input  logic [31:0]       word_i,
  output logic              q_push_o,
  output e1wrd_pkg::entry_t q_entry_o
);
  import e1wrd_pkg::*;

  logic        held_q, held_d;
  logic [31:0] hword_q, hword_d;
  logic [13:0] wl_q, wl_d;
  logic [15:0] sl_q, sl_d;
  logic        accept;
  logic        gen;
  entry_t      entry;
  logic [63:0] both;
  logic [2:0]  n;
  logic [2:0]  cnt;
  logic [15:0] size;
  logic [7:0]  ord_b;

  assign accept = push_i && !full_i;
  assign both   = held_q ? {hword_q, word_i} : {word_i, 32'd0};
  assign size   = word_i[31:16];
  assign ord_b  = word_i[31:24];

  always_comb begin
    entry   = '0;
    gen     = 1'b0;
    held_d  = held_q;
    hword_d = hword_q;
    wl_d    = wl_q;
    sl_d    = sl_q;
    n       = 3'd0;
    cnt     = 3'd0;
    unique case (kind_e'(kind_i))
      KIND_HDR_SIZE: begin
        held_d    = 1'b0;
        wl_d      = (size >= 16'd8) ? 14'((size >> 2) - 16'd2) : 14'd0;
        sl_d      = word_i[15:0];
        gen       = 1'b1;
        entry.op  = OP_CLEAR;
        entry.cnt = 3'd1;
      end
      KIND_HDR_CHECK: begin
        held_d     = 1'b0;
        gen        = 1'b1;
        entry.op   = OP_LOAD;
        entry.cnt  = 3'd1;
        entry.ord  = (ord_b > 8'(MAX_ORDER)) ? ORD_W'(MAX_ORDER) : ord_b[ORD_W-1:0];
        entry.bits = {{8{word_i[23]}}, word_i[23:0], 32'd0};
      end
      KIND_DATA: begin
        if (wl_q != 14'd0 && sl_q != 16'd0) begin
          wl_d     = wl_q - 14'd1;
          entry.op = OP_DATA;
          if (held_q) begin
            held_d = 1'b0;
            if (!hword_q[31]) begin
              entry.map = MAP_9X7;
              n         = 3'd7;
            end else if (hword_q[31:28] == 4'hd) begin
              entry.map = MAP_12X5;
              n         = 3'd5;
            end else begin
              entry.map = MAP_15X4;
              n         = 3'd4;
            end
          end else if (!word_i[31] || word_i[31:28] == 4'hd || word_i[31:28] == 4'he) begin
            if (wl_q != 14'd1) begin
              held_d  = 1'b1;
              hword_d = word_i;
            end
          end else if (word_i[31:30] == 2'b10) begin
            entry.map = MAP_10X3;
            n         = 3'd3;
          end else if (word_i[31:28] == 4'hc) begin
            entry.map = MAP_7X4;
            n         = 3'd4;
          end else begin
            entry.map = MAP_28X1;
            n         = 3'd1;
          end
          if (n != 3'd0) begin
            cnt        = (sl_q < 16'(n)) ? sl_q[2:0] : n;
            sl_d       = sl_q - 16'(cnt);
            gen        = 1'b1;
            entry.cnt  = cnt;
            entry.ends = (sl_q == 16'(cnt));
            case (entry.map)
              MAP_9X7:  entry.bits = both << 1;
              MAP_10X3: entry.bits = both << 2;
              default:  entry.bits = both << 4;
            endcase
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 1'b0;
      wl_q   <= '0;
      sl_q   <= '0;
    end else if (accept) begin
      held_q <= held_d;
      wl_q   <= wl_d;
      sl_q   <= sl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hword_q <= hword_d;
    end
  end

  assign q_push_o  = accept && gen;
  assign q_entry_o = entry;

endmodule

// File: rtl/e1wrd_fifo.sv
// ----------------------------------------------------------------------------
// e1wrd_fifo
// Short queue of commands between the front and the back end.
// ----------------------------------------------------------------------------
module e1wrd_fifo #(
  parameter int DEPTH = e1wrd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  e1wrd_pkg::entry_t wdata_i,
  output logic              full_o,
  input  logic              pop_i,
  output e1wrd_pkg::entry_t rdata_o,
  output logic              empty_o
);
  import e1wrd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t        mem_q [DEPTH];
  logic [PW-1:0] wp_q, rp_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + PW'(1);
      end
      if (do_pop) begin
        rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (!do_push && do_pop) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

// File: rtl/e1wrd_back.sv
// ----------------------------------------------------------------------------
// e1wrd_back
// Unpacks queued groups one sample a cycle unless stalled, runs them through a
// pipelined chain of running sums and holds the result word for the consumer.
// ----------------------------------------------------------------------------
module e1wrd_back #(
  parameter int MAX_ORDER = e1wrd_pkg::MAX_ORDER_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  e1wrd_pkg::entry_t q_entry_i,
  output logic              q_pop_o,
  input  logic              pop_i,
  output logic              empty_o,
  output logic [31:0]       sample_o,
  output logic              last_o,
  output logic              record_end_o,
  output logic              check_error_o
);
  import e1wrd_pkg::*;

  logic             adv;
  logic             busy_q;
  op_e              op_q;
  logic [ORD_W-1:0] ord_q;
  logic [2:0]       cnt_q;
  logic             ends_q;
  logic [63:0]      bits_q;
  logic [4:0]       fw_q;
  logic [4:0]       shamt;
  tok_t             seq_tok;

  tok_t             tok_q [MAX_ORDER];
  logic [31:0]      integ_q [MAX_ORDER];
  tok_t             tail;

  logic             out_valid_q;
  logic [31:0]      out_sample_q;
  logic             out_last_q, out_end_q, out_err_q;
  logic [31:0]      check_q;

  assign adv     = !out_valid_q || pop_i;
  assign q_pop_o = !busy_q && !q_empty_i;
  assign shamt   = 5'(6'd32 - 6'(fw_q));

  always_comb begin
    seq_tok       = '0;
    seq_tok.valid = busy_q;
    seq_tok.op    = op_q;
    seq_tok.ord   = ord_q;
    seq_tok.last  = (cnt_q == 3'd1);
    seq_tok.ends  = ends_q && (cnt_q == 3'd1);
    seq_tok.val   = (op_q == OP_DATA) ? 32'($signed(bits_q[63:32]) >>> shamt)
                                      : bits_q[63:32];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ord_q  <= '0;
      op_q   <= OP_CLEAR;
      cnt_q  <= '0;
    end else if (q_pop_o) begin
      busy_q <= 1'b1;
      op_q   <= q_entry_i.op;
      cnt_q  <= q_entry_i.cnt;
      if (q_entry_i.op == OP_LOAD) begin
        ord_q <= q_entry_i.ord;
      end
    end else if (busy_q && adv) begin
      cnt_q <= cnt_q - 3'd1;
      if (cnt_q == 3'd1) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      bits_q <= q_entry_i.bits;
      ends_q <= q_entry_i.ends;
      fw_q   <= map_fw(q_entry_i.map);
    end else if (busy_q && adv) begin
      bits_q <= bits_q << fw_q;
    end
  end

  for (genvar i = 0; i < MAX_ORDER; i++) begin : g_stage
    tok_t        tin, tout;
    logic [31:0] sum;
    logic        use_stage;

    if (i == 0) begin : g_first
      assign tin = seq_tok;
    end else begin : g_next
      assign tin = tok_q[i-1];
    end

    assign sum       = integ_q[i] + tin.val;
    assign use_stage = (tin.op == OP_DATA) && (tin.ord > ORD_W'(i));

    always_comb begin
      tout = tin;
      if (use_stage) begin
        tout.val = sum;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tok_q[i]   <= '0;
        integ_q[i] <= '0;
      end else if (adv) begin
        tok_q[i] <= tout;
        if (tin.valid) begin
          if (tin.op == OP_CLEAR || tin.op == OP_LOAD) begin
            integ_q[i] <= '0;
          end else if (use_stage) begin
            integ_q[i] <= sum;
          end
        end
      end
    end
  end

  assign tail = tok_q[MAX_ORDER-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      check_q     <= '0;
    end else if (adv) begin
      out_valid_q <= tail.valid && (tail.op == OP_DATA);
      if (tail.valid && tail.op == OP_LOAD) begin
        check_q <= tail.val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && tail.valid && tail.op == OP_DATA) begin
      out_sample_q <= tail.val;
      out_last_q   <= tail.last;
      out_end_q    <= tail.ends;
      out_err_q    <= tail.ends && (tail.val != check_q);
    end
  end

  assign empty_o       = !out_valid_q;
  assign sample_o      = out_sample_q;
  assign last_o        = out_last_q;
  assign record_end_o  = out_end_q;
  assign check_error_o = out_err_q;

endmodule

// File: rtl/e1_waveform_record_decoder.sv
// ----------------------------------------------------------------------------
// e1_waveform_record_decoder
// Decodes e1 compressed seismic records into integrated 32-bit samples.
// ----------------------------------------------------------------------------
// A data word passes through the queue, the unpack sequencer, the running-sum
// chain and the output register. Samples leave the chain at one per cycle
// while the output is not stalled; the sequencer takes no new group or header
// until the last one is unpacked. Words enter at one per cycle until the queue
// fills. Reset (async, active low) clears all record state; no sweep.
module e1_waveform_record_decoder #(
  parameter int MAX_ORDER   = e1wrd_pkg::MAX_ORDER_DEF,
  parameter int QUEUE_DEPTH = e1wrd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic [1:0]  kind_i,
  input  logic [31:0] word_i,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [31:0] sample_o,
  output logic        last_o,
  output logic        record_end_o,
  output logic        check_error_o
);
  import e1wrd_pkg::*;

  logic   q_push, q_pop, q_full, q_empty;
  entry_t q_wdata, q_rdata;

  assign full_o = q_full;

  e1wrd_front #(.MAX_ORDER(MAX_ORDER)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push_i),
    .full_i    (q_full),
    .kind_i    (kind_i),
    .word_i    (word_i),
    .q_push_o  (q_push),
    .q_entry_o (q_wdata)
  );

  e1wrd_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  e1wrd_back #(.MAX_ORDER(MAX_ORDER)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_entry_i     (q_rdata),
    .q_pop_o       (q_pop),
    .pop_i         (pop_i),
    .empty_o       (empty_o),
    .sample_o      (sample_o),
    .last_o        (last_o),
    .record_end_o  (record_end_o),
    .check_error_o (check_error_o)
  );

  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("queue written while full");

  a_no_pop_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("queue read while empty");

  a_end_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && record_end_o) |-> last_o)
    else $error("record end not on last sample of its word");

  a_err_at_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && check_error_o) |-> record_end_o)
    else $error("check error away from record end");

endmodule

// File: bench/tb_e1_waveform_record_decoder.sv
// ----------------------------------------------------------------------------
// tb_e1_waveform_record_decoder
// Self-checking bench for the e1 waveform record decoder. Header and data
// words go in through the push side. A built-in decoder model predicts every
// integrated sample with its last, record-end and check-error flags, and each
// popped sample is compared against that prediction in order. Directed
// corner records come first, then random records with some broken ones and
// noise mixed in. Both sides idle at random, and one long pop stall fills
// the block up.
// ----------------------------------------------------------------------------
module tb_e1_waveform_record_decoder;
  import e1wrd_pkg::*;

  localparam int          MAX_ORD     = MAX_ORDER_DEF;
  localparam int          STALL_LIMIT = 2000;
  localparam int          HOLD_CYCLES = 60;
  localparam int          WORD_TARGET = 180;
  localparam logic [1:0]  KIND_UNUSED = 2'd3;

  localparam logic [31:0] MASK1  = 32'h8000_0000;
  localparam logic [31:0] MASK2  = 32'hc000_0000;
  localparam logic [31:0] MASK4  = 32'hf000_0000;
  localparam logic [31:0] P_10X3 = 32'h8000_0000;
  localparam logic [31:0] P_7X4  = 32'hc000_0000;
  localparam logic [31:0] P_12X5 = 32'hd000_0000;
  localparam logic [31:0] P_15X4 = 32'he000_0000;
  localparam logic [31:0] LOW28  = 32'h0fff_ffff;

  typedef struct {
    logic [31:0] sample;
    logic        last;
    logic        rec_end;
    logic        chk_err;
  } sample_t;

  class record_decode_board;
    sample_t     due_samples[$];
    logic [31:0] integ[MAX_ORD];
    logic [31:0] held_word;
    logic        held_valid;
    int          order;
    logic [23:0] check_val;
    logic [13:0] words_left;
    logic [15:0] samples_left;
    int          errors;
    int          words_used;
    int          checked;
    int          ends_seen;
    int          bad_checks;

    function new();
      clear_record();
      order        = 0;
      check_val    = '0;
      words_left   = '0;
      samples_left = '0;
      errors       = 0;
      words_used   = 0;
      checked      = 0;
      ends_seen    = 0;
      bad_checks   = 0;
    endfunction

    function void clear_record();
      for (int i = 0; i < MAX_ORD; i++) integ[i] = '0;
      held_word  = '0;
      held_valid = 1'b0;
    endfunction

    function logic [31:0] sext(logic [31:0] v, int n);
      logic [31:0] m;
      m = (n >= 32) ? '1 : ((32'd1 << n) - 32'd1);
      v &= m;
      if (n < 32 && v[n-1]) v |= ~m;
      return v;
    endfunction

    function logic [31:0] integrate(logic [31:0] x);
      logic [31:0] acc;
      acc = x;
      for (int i = 0; i < order && i < MAX_ORD; i++) begin
        integ[i] += acc;
        acc = integ[i];
      end
      return acc;
    endfunction

    function void note_word(logic [1:0] kd, logic [31:0] w);
      logic [31:0] raw[7];
      logic [63:0] bits;
      logic [31:0] first;
      sample_t     e;
      int          n, fw, pre, total;
      n = 0;
      fw = 28;
      pre = 4;
      total = 32;
      words_used++;
      if (kd == KIND_HDR_SIZE) begin
        clear_record();
        words_left   = (w[31:16] >= 16'd8) ? 14'((w[31:16] >> 2) - 16'd2) : '0;
        samples_left = w[15:0];
        return;
      end
      if (kd == KIND_HDR_CHECK) begin
        clear_record();
        order     = (w[31:24] > MAX_ORD) ? MAX_ORD : int'(w[31:24]);
        check_val = w[23:0];
        return;
      end
      if (kd != KIND_DATA || words_left == 0 || samples_left == 0) return;
      words_left--;
      if (held_valid) begin
        bits       = {held_word, w};
        first      = held_word;
        held_valid = 1'b0;
        held_word  = '0;
        total      = 64;
        if ((first & MASK1) == '0) begin
          pre = 1; fw = 9; n = 7;
        end else if ((first & MASK4) == P_12X5) begin
          fw = 12; n = 5;
        end else begin
          fw = 15; n = 4;
        end
      end else if ((w & MASK1) == '0 || (w & MASK4) == P_12X5 ||
                   (w & MASK4) == P_15X4) begin
        // a pair that starts on the final word is dropped
        if (words_left != 0) begin
          held_word  = w;
          held_valid = 1'b1;
        end
        return;
      end else begin
        bits = {32'd0, w};
        if ((w & MASK2) == P_10X3) begin
          pre = 2; fw = 10; n = 3;
        end else if ((w & MASK4) == P_7X4) begin
          fw = 7; n = 4;
        end else begin
          bits = {32'd0, w & LOW28};
          fw = 28; n = 1;
        end
      end
      for (int i = 0; i < n; i++) raw[i] = sext(32'(bits >> (total - pre - fw * (i + 1))), fw);
      for (int i = 0; i < n && samples_left != 0; i++) begin
        e.sample = integrate(raw[i]);
        samples_left--;
        e.rec_end = (samples_left == 0);
        e.last    = (i == n - 1) || e.rec_end;
        e.chk_err = e.rec_end && (e.sample != sext({8'd0, check_val}, 24));
        due_samples.push_back(e);
      end
    endfunction

    function void cmp_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
      if (exp_v !== got_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
      end
    endfunction

    function void check_sample(logic [31:0] s, logic l, logic re, logic ce);
      sample_t e;
      if (due_samples.size() == 0) begin
        errors++;
        $display("%0t: unexpected sample, expected none, actual %h", $time, s);
        return;
      end
      e = due_samples.pop_front();
      checked++;
      if (e.rec_end) ends_seen++;
      if (e.chk_err) bad_checks++;
      cmp_field("sample", e.sample, s);
      cmp_field("last", 32'(e.last), 32'(l));
      cmp_field("record_end", 32'(e.rec_end), 32'(re));
      cmp_field("check_error", 32'(e.chk_err), 32'(ce));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push_i = 1'b0;
  logic        full_o;
  logic [1:0]  kind_i = '0;
  logic [31:0] word_i = '0;
  logic        empty_o;
  logic        pop_i = 1'b0;
  logic [31:0] sample_o;
  logic        last_o;
  logic        record_end_o;
  logic        check_error_o;

  record_decode_board board = new();
  int phase = 0;
  int send_idle = 29;
  int recv_idle = 71;
  int stall_cnt = 0;

  e1_waveform_record_decoder u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push_i),
    .full_o        (full_o),
    .kind_i        (kind_i),
    .word_i        (word_i),
    .empty_o       (empty_o),
    .pop_i         (pop_i),
    .sample_o      (sample_o),
    .last_o        (last_o),
    .record_end_o  (record_end_o),
    .check_error_o (check_error_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if ((push_i && !full_o) || (pop_i && !empty_o)) begin
      stall_cnt = 0;
    end else begin
      stall_cnt++;
    end
    if (stall_cnt >= STALL_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  // pop side, with one long hold when the no-idle phase starts
  initial begin
    int  hold_cnt;
    bit  held_done;
    hold_cnt  = 0;
    held_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop_i && !empty_o)
        board.check_sample(sample_o, last_o, record_end_o, check_error_o);
      if (phase == 2 && !held_done) begin
        held_done = 1'b1;
        hold_cnt  = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        pop_i <= 1'b0;
      end else begin
        pop_i <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  task automatic send_word(logic [1:0] kd, logic [31:0] w);
    while ($urandom_range(0, 99) < send_idle) begin
      push_i <= 1'b0;
      @(posedge clk_i);
    end
    push_i <= 1'b1;
    kind_i <= kd;
    word_i <= w;
    @(posedge clk_i);
    while (full_o) @(posedge clk_i);
    board.note_word(kd, w);
    if (board.words_used >= 2 * WORD_TARGET / 3) begin
      phase = 2;
      send_idle = 0;
      recv_idle = 0;
    end else if (board.words_used >= WORD_TARGET / 3) begin
      phase = 1;
      send_idle = 71;
      recv_idle = 29;
    end
  endtask

  function automatic int words_of(map_e m);
    return (m == MAP_9X7 || m == MAP_12X5 || m == MAP_15X4) ? 2 : 1;
  endfunction

  function automatic int samples_of(map_e m);
    case (m)
      MAP_9X7:  return 7;
      MAP_10X3: return 3;
      MAP_7X4:  return 4;
      MAP_12X5: return 5;
      MAP_15X4: return 4;
      default:  return 1;
    endcase
  endfunction

  task automatic send_group(map_e m);
    logic [31:0] w;
    w = $urandom;
    case (m)
      MAP_9X7:  w = w & ~MASK1;
      MAP_10X3: w = (w & ~MASK2) | P_10X3;
      MAP_7X4:  w = (w & ~MASK4) | P_7X4;
      MAP_12X5: w = (w & ~MASK4) | P_12X5;
      MAP_15X4: w = (w & ~MASK4) | P_15X4;
      default:  w = w | MASK4;
    endcase
    send_word(KIND_DATA, w);
    if (words_of(m) == 2) send_word(KIND_DATA, $urandom);
  endtask

  task automatic send_record();
    map_e        maps[$];
    int          nwords, nsamp, sz, cnt, style;
    bit          match;
    logic [7:0]  ord;
    logic [23:0] chk;
    nwords = 0;
    nsamp  = 0;
    match  = ($urandom_range(0, 3) == 0);
    repeat ($urandom_range(1, 4)) maps.push_back(map_e'($urandom_range(0, 5)));
    foreach (maps[i]) begin
      nwords += words_of(maps[i]);
      nsamp  += samples_of(maps[i]);
    end
    if (match) begin
      nwords++;
      nsamp++;
    end
    style = match ? 0 : $urandom_range(0, 9);
    sz    = (nwords + 2) * 4 + $urandom_range(0, 3);
    cnt   = nsamp;
    ord   = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, MAX_ORD));
    chk   = 24'($urandom);
    if (match) ord = '0;
    case (style)
      7:       cnt = $urandom_range(0, nsamp);
      8:       cnt = nsamp + $urandom_range(1, 10);
      9:       sz  = sz - 4 * $urandom_range(1, nwords);
      default: ;
    endcase
    send_word(KIND_HDR_SIZE, {16'(sz), 16'(cnt)});
    if (match || $urandom_range(0, 7) != 0) send_word(KIND_HDR_CHECK, {ord, chk});
    foreach (maps[i]) send_group(maps[i]);
    if (match) send_word(KIND_DATA, {4'hf, {4{chk[23]}}, chk});
    if ($urandom_range(0, 5) == 0) send_group(map_e'($urandom_range(0, 5)));
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(KIND_DATA, 32'hffff_ffff);
    send_word(KIND_UNUSED, 32'hffff_ffff);
    send_word(KIND_HDR_CHECK, 32'hff80_0000);
    send_word(KIND_HDR_SIZE, 32'hffff_ffff);
    send_word(KIND_DATA, 32'h7fff_ffff);
    send_word(KIND_DATA, 32'h0000_0000);
    send_word(KIND_DATA, 32'h9ff7_fdff);
    send_word(KIND_DATA, 32'hc000_0000);
    send_word(KIND_DATA, 32'hd800_0000);
    send_word(KIND_DATA, 32'h0000_0000);
    send_word(KIND_DATA, 32'hefff_ffff);
    send_word(KIND_DATA, 32'hffff_ffff);
    send_word(KIND_DATA, 32'hf7ff_ffff);
    send_word(KIND_DATA, 32'hf800_0000);
    send_word(KIND_DATA, 32'hbfff_ffff);
    // size below 8 bytes, then a zero sample count
    send_word(KIND_HDR_SIZE, 32'h0004_0005);
    send_word(KIND_DATA, 32'hf000_0001);
    send_word(KIND_HDR_SIZE, 32'h0010_0000);
    send_word(KIND_DATA, 32'hf000_0001);
    // pair starting on the final word
    send_word(KIND_HDR_SIZE, 32'h000c_000a);
    send_word(KIND_HDR_CHECK, 32'h007f_ffff);
    send_word(KIND_DATA, 32'h1234_5678);
    // count reached with a matching check, later words ignored
    send_word(KIND_HDR_SIZE, 32'h0014_0001);
    send_word(KIND_DATA, 32'hf07f_ffff);
    send_word(KIND_DATA, 32'h8000_0000);

    while (board.words_used < WORD_TARGET) begin
      if ($urandom_range(0, 9) == 0) begin
        send_word(2'($urandom_range(0, 3)), $urandom);
      end else begin
        send_record();
      end
    end
    push_i <= 1'b0;

    while (board.due_samples.size() != 0) @(posedge clk_i);
    repeat (MAX_ORD + 12) @(posedge clk_i);
    $display("%0d words sent, %0d samples checked, %0d record ends (%0d with a check mismatch)",
             board.words_used, board.checked, board.ends_seen, board.bad_checks);
    if (board.errors == 0 && board.due_samples.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
